// File: hdl/odrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odrs_pkg
// Shared constants, types and lookup functions of the ordered-dither
// rotate scaler.
// ----------------------------------------------------------------------------
package odrs_pkg;

    // frame geometry
    localparam int SRC_WIDTH  = 160;
    localparam int SRC_HEIGHT = 144;
    localparam int SCALE      = 3;
    localparam int OUT_WIDTH  = 480;

    localparam int PIX_PER_BYTE = 4;
    localparam int IDX_W        = 17;
    localparam int MASK_W       = 8;
    localparam int STRIDE_W     = 8;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd100;
    localparam logic [MASK_W-1:0]   MASK_MSB     = 8'h80;

    localparam int COL_W = $clog2(SRC_WIDTH + PIX_PER_BYTE);
    localparam int ROW_W = $clog2(SRC_HEIGHT + 1);
    localparam int LX_W  = $clog2((SRC_WIDTH + PIX_PER_BYTE) * SCALE + 1);
    localparam int NX_W  = $clog2(SRC_HEIGHT * SCALE + 1);
    localparam int SC_W  = $clog2(SCALE + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // 4x4 threshold matrix, entry (row*4+col) at nibble row*4+col
    localparam logic [63:0] BAYER_FLAT = 64'h5D7F_91B3_6E4C_A280;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic [7:0] packed_pixels;
        col_t       col;
        row_t       row;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [4:0] shade_level(input logic [1:0] shade);
        logic [4:0] lvl;
        case (shade)
            2'd0:    lvl = 5'd0;
            2'd1:    lvl = 5'd5;
            2'd2:    lvl = 5'd11;
            default: lvl = 5'd16;
        endcase
        return lvl;
    endfunction

    function automatic logic [3:0] bayer_thresh(input logic [1:0] brow, input logic [1:0] bcol);
        return BAYER_FLAT[{brow, bcol, 2'b00} +: 4];
    endfunction

endpackage

// File: hdl/odrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odrs_front
// Accepts packed source bytes, tags each with its source column and row,
// and advances the raster position.
// ----------------------------------------------------------------------------
module odrs_front
    import odrs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // [7:0] packed_pixels
    input  logic [0:0]    s_tuser,    // [0] frame_start
    input  queue_status_t q_status,
    output logic          push_valid,
    output item_t         push_item
);

    col_t col_reg, col_next;
    row_t row_reg, row_next;
    col_t cur_col;
    row_t cur_row;
    logic [COL_W:0] col_sum;
    logic [ROW_W:0] row_sum;

    assign s_tready   = !q_status.full;
    assign push_valid = s_tvalid && s_tready;

    // frame start overrides the running position for this byte
    assign cur_col = s_tuser[0] ? '0 : col_reg;
    assign cur_row = s_tuser[0] ? '0 : row_reg;

    assign push_item.packed_pixels = s_tdata;
    assign push_item.col           = cur_col;
    assign push_item.row           = cur_row;

    always_comb
    begin
        col_sum  = {1'b0, cur_col} + (COL_W+1)'(PIX_PER_BYTE);
        row_sum  = {1'b0, cur_row} + (ROW_W+1)'(1);
        col_next = col_t'(col_sum);
        row_next = cur_row;
        if (col_sum >= (COL_W+1)'(SRC_WIDTH))
        begin
            col_next = '0;
            row_next = (row_sum >= (ROW_W+1)'(SRC_HEIGHT)) ? '0 : row_t'(row_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push_valid)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: hdl/odrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odrs_queue
// Short FIFO of tagged source bytes between the front and the back.
// ----------------------------------------------------------------------------
module odrs_queue
    import odrs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         pop_item,
    output queue_status_t q_status
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign pop_item       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_valid)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push_valid && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push_valid)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: hdl/odrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odrs_back
// Walks pixel, dy, dx of one byte, one bit write per cycle while m_tready
// does not stall the output, and forms the rotated byte address, mask and
// dither decision in a registered output.
module odrs_back
    import odrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [STRIDE_W-1:0] stride,
    input  queue_status_t       q_status,
    input  item_t               q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,  // [16:0] byte_index, [24:17] pixel_mask, zero pad
    output logic [0:0]          m_tuser,  // [0] dark
    output logic                m_tlast   // last_of_item
);

    // generator state
    logic             gen_valid_reg;
    logic [1:0]       p_reg;
    logic [SC_W-1:0]  dy_reg, dx_reg;
    logic [LX_W-1:0]  lx_reg;
    logic [NX_W-1:0]  natx_reg, natx_base_reg;
    logic [7:0]       packed_reg;

    // output stage
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic [MASK_W-1:0] out_mask_reg, out_mask_next;
    logic              out_dark_reg, out_dark_next;
    logic              out_last_reg;

    logic             out_ready, gen_take, gen_last, load;
    logic [IDX_W-1:0] lx_ext, natx_ext, nat_y;
    logic [7:0]       shifted;
    logic [4:0]       level;
    logic [3:0]       thresh;

    assign out_ready = !out_valid_reg || m_tready;
    assign gen_take  = gen_valid_reg && out_ready;
    assign gen_last  = (p_reg == 2'd3) && (dy_reg == SC_W'(SCALE-1))
                       && (dx_reg == SC_W'(SCALE-1));
    assign load      = !q_status.empty && (!gen_valid_reg || (gen_take && gen_last));
    assign q_pop     = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_valid_reg <= 1'b0;
            p_reg         <= '0;
            dy_reg        <= '0;
            dx_reg        <= '0;
            lx_reg        <= '0;
            natx_reg      <= '0;
            natx_base_reg <= '0;
            packed_reg    <= '0;
        end
        else if (load)
        begin
            gen_valid_reg <= 1'b1;
            p_reg         <= '0;
            dy_reg        <= '0;
            dx_reg        <= '0;
            lx_reg        <= LX_W'(q_item.col) * LX_W'(SCALE);
            natx_reg      <= NX_W'(q_item.row) * NX_W'(SCALE);
            natx_base_reg <= NX_W'(q_item.row) * NX_W'(SCALE);
            packed_reg    <= q_item.packed_pixels;
        end
        else if (gen_take)
        begin
            if (gen_last)
                gen_valid_reg <= 1'b0;
            else if (dx_reg != SC_W'(SCALE-1))
            begin
                dx_reg <= dx_reg + 1'b1;
                lx_reg <= lx_reg + 1'b1;
            end
            else if (dy_reg != SC_W'(SCALE-1))
            begin
                // back to the first column of this pixel, next native x
                dx_reg   <= '0;
                dy_reg   <= dy_reg + 1'b1;
                natx_reg <= natx_reg + 1'b1;
                lx_reg   <= lx_reg - LX_W'(SCALE-1);
            end
            else
            begin
                // next pixel starts one past the current logical x
                dx_reg   <= '0;
                dy_reg   <= '0;
                p_reg    <= p_reg + 1'b1;
                natx_reg <= natx_base_reg;
                lx_reg   <= lx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        lx_ext         = IDX_W'(lx_reg);
        natx_ext       = IDX_W'(natx_reg);
        nat_y          = IDX_W'(OUT_WIDTH-1) - lx_ext;
        shifted        = packed_reg >> {p_reg, 1'b0};
        level          = shade_level(shifted[1:0]);
        thresh         = bayer_thresh(natx_ext[1:0], lx_ext[1:0]);
        out_index_next = nat_y * IDX_W'(stride) + (natx_ext >> 3);
        out_mask_next  = MASK_MSB >> natx_ext[2:0];
        out_dark_next  = (level > {1'b0, thresh});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= gen_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (gen_take)
        begin
            out_index_reg <= out_index_next;
            out_mask_reg  <= out_mask_next;
            out_dark_reg  <= out_dark_next;
            out_last_reg  <= gen_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_mask_reg, out_index_reg};
    assign m_tuser  = out_dark_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/ordered_dither_rotate_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_dither_rotate_scaler
// 2-bpp source to 1-bpp rotated, scaled, Bayer 4x4 dithered bit writes.
// ----------------------------------------------------------------------------
// Each accepted source byte (four pixels, raster order) produces
// 4*SCALE*SCALE framebuffer bit writes, 36 at the default SCALE of 3, issued
// one per cycle by the back-end sequencer unless m_tready stalls the output;
// that sequencer sets the sustained byte rate. The front end tags each byte
// with its source position and parks it in a two-entry queue, so up to three
// bytes are held (plus the write waiting in the output register) and new
// bytes are taken while writes are still going out. A byte passes the queue
// entry, generator registers and output register before its first write. The
// last write of each byte carries tlast; tuser on the output is the dark flag
// (1 clears the bit). The user must write row_stride_bytes through cfg_we/
// cfg_wdata only while the block is idle; the block does not enforce this.
module ordered_dither_rotate_scaler
    import odrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [STRIDE_W-1:0] cfg_wdata,  // row_stride_bytes
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] packed_pixels
    input  logic [0:0]          s_tuser,    // [0] frame_start
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,    // [16:0] byte_index, [24:17] pixel_mask
    output logic [0:0]          m_tuser,    // [0] dark
    output logic                m_tlast     // last_of_item
);

    logic [STRIDE_W-1:0] stride_reg;
    queue_status_t       q_status;
    logic                push_valid;
    item_t               push_item;
    item_t               q_item;
    logic                q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stride_reg <= STRIDE_RESET;
        else if (cfg_we)
            stride_reg <= cfg_wdata;
    end

    odrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    odrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (q_pop),
        .pop_item   (q_item),
        .q_status   (q_status)
    );

    odrs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .stride   (stride_reg),
        .q_status (q_status),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // every write addresses exactly one bit
    a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(m_tdata[24:17]))
        else $error("pixel mask not one-hot");

    // a frame-start byte is tagged with the origin
    a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |-> (push_item.col == '0 && push_item.row == '0))
        else $error("frame start did not reset position");

    // tagged positions stay inside the source frame
    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_item.col < COL_W'(SRC_WIDTH) && push_item.row < ROW_W'(SRC_HEIGHT)))
        else $error("source position out of range");

    // no pop from an empty queue
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
